[hw/rtl/ratalu_pkg.sv]
// ----------------------------------------------------------------------------
// ratalu_pkg
// Shared widths and operation codes for the rational ALU.
// ----------------------------------------------------------------------------
package ratalu_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int NUM_W         = PROD_W + 1;
	localparam int DEN_W         = PROD_W;
	localparam int MAG_W         = PROD_W;
	localparam int OP_CNT_W      = $clog2(OPERAND_WIDTH);
	localparam int MAG_CNT_W     = $clog2(MAG_W);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

endpackage

[hw/rtl/rational_alu_with_reduction.sv]
// ----------------------------------------------------------------------------
// rational_alu_with_reduction
// Fraction add/subtract/multiply/divide with gcd reduction of the result.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): req_type plus two signed fractions
// a_num/a_den and b_num/b_den. A transfer happens when in_valid is high and
// in_stall is low. in_stall is high from the transfer until the result has
// moved into the output register, so one item is worked on at a time.
// Output channel (out_valid/out_stall): res_num/res_den, one transfer per
// input item. The output register lets a new item enter while the previous
// result still waits for the receiver.
// Sequence: serial multiply (one multiplier bit a cycle), a latch of the
// products, a check state, then binary gcd (one shift or subtract a cycle,
// then the common power of two shifted back in), then bit-serial divide of
// both parts by the gcd. A zero numerator or denominator skips gcd and
// divide. The next transfer can be taken once the result is registered.
// Reset: all control clears, the output register is empty, in_stall is low.
// Receiver stall: the finished result waits in the last state until the
// output register frees up; nothing is dropped or overwritten.
// ----------------------------------------------------------------------------
module rational_alu_with_reduction (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic [1:0]                                  req_type,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] a_num,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] a_den,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] b_num,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] b_den,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic signed [ratalu_pkg::NUM_W-1:0]         res_num,
	output logic signed [ratalu_pkg::DEN_W-1:0]         res_den
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_GCD,
		ST_DIV,
		ST_FIN
	} alu_state_t;

	alu_state_t                       state_q;
	ratalu_pkg::op_t                  op_q;
	logic                             accept;
	logic                             out_free;

	// multiplier operand selection and products
	logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] t1_b;
	logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] den_b;
	logic signed [ratalu_pkg::PROD_W-1:0]        t1_prod;
	logic signed [ratalu_pkg::PROD_W-1:0]        t2_prod;
	logic signed [ratalu_pkg::PROD_W-1:0]        den_prod;
	logic                                        t1_done;
	logic                                        t2_done;
	logic                                        den_done;
	logic [ratalu_pkg::NUM_W-1:0]                t1_x;
	logic [ratalu_pkg::NUM_W-1:0]                t2_x;
	logic [ratalu_pkg::NUM_W-1:0]                num_comb;

	// working fraction and its magnitudes
	logic [ratalu_pkg::NUM_W-1:0] num_q;
	logic [ratalu_pkg::DEN_W-1:0] den_q;
	logic [ratalu_pkg::NUM_W-1:0] num_abs;
	logic [ratalu_pkg::DEN_W-1:0] den_abs;
	logic [ratalu_pkg::MAG_W-1:0] num_mag;
	logic [ratalu_pkg::MAG_W-1:0] den_mag;

	// gcd and divide units
	logic                         gcd_start_q;
	logic                         gcd_done;
	logic [ratalu_pkg::MAG_W-1:0] gcd_val;
	logic                         div_start_q;
	logic                         divn_done;
	logic                         divd_done;
	logic [ratalu_pkg::MAG_W-1:0] quo_n;
	logic [ratalu_pkg::MAG_W-1:0] quo_d;
	logic [ratalu_pkg::MAG_W-1:0] rem_n;
	logic [ratalu_pkg::MAG_W-1:0] rem_d;

	// output register
	logic                         out_valid_q;
	logic [ratalu_pkg::NUM_W-1:0] out_num_q;
	logic [ratalu_pkg::DEN_W-1:0] out_den_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// multiply: t1 = a_num * b_den (b_num for multiply), t2 = b_num * a_den,
	// den = a_den * b_den (b_num for divide)
	assign t1_b  = (req_type == ratalu_pkg::OP_MUL) ? b_num : b_den;
	assign den_b = (req_type == ratalu_pkg::OP_DIV) ? b_num : b_den;

	ratalu_mul u_mul_t1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.a      (a_num),
		.b      (t1_b),
		.done   (t1_done),
		.prod   (t1_prod)
	);

	ratalu_mul u_mul_t2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.a      (b_num),
		.b      (a_den),
		.done   (t2_done),
		.prod   (t2_prod)
	);

	ratalu_mul u_mul_den (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.a      (a_den),
		.b      (den_b),
		.done   (den_done),
		.prod   (den_prod)
	);

	assign t1_x = {t1_prod[ratalu_pkg::PROD_W-1], t1_prod};
	assign t2_x = {t2_prod[ratalu_pkg::PROD_W-1], t2_prod};

	always_comb begin
		unique case (op_q)
			ratalu_pkg::OP_ADD: num_comb = t1_x + t2_x;
			ratalu_pkg::OP_SUB: num_comb = t1_x - t2_x;
			ratalu_pkg::OP_MUL: num_comb = t1_x;
			ratalu_pkg::OP_DIV: num_comb = t1_x;
			default:            num_comb = t1_x;
		endcase
	end

	// magnitudes fit MAG_W bits: the numerator never reaches -2^(NUM_W-1)
	assign num_abs = num_q[ratalu_pkg::NUM_W-1] ? (~num_q + 1'b1) : num_q;
	assign den_abs = den_q[ratalu_pkg::DEN_W-1] ? (~den_q + 1'b1) : den_q;
	assign num_mag = num_abs[ratalu_pkg::MAG_W-1:0];
	assign den_mag = den_abs;

	ratalu_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start_q),
		.x      (num_mag),
		.y      (den_mag),
		.done   (gcd_done),
		.g      (gcd_val)
	);

	ratalu_div u_div_num (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.dvd    (num_mag),
		.dvs    (gcd_val),
		.done   (divn_done),
		.quo    (quo_n),
		.rem    (rem_n)
	);

	ratalu_div u_div_den (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.dvd    (den_mag),
		.dvs    (gcd_val),
		.done   (divd_done),
		.quo    (quo_d),
		.rem    (rem_d)
	);

	// sequencer, working fraction and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= ratalu_pkg::OP_ADD;
			num_q       <= '0;
			den_q       <= '0;
			gcd_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_num_q   <= '0;
			out_den_q   <= '0;
		end else begin
			// one-cycle start pulses for the gcd and divide units
			gcd_start_q <= (state_q == ST_CHK) && (num_q != '0) && (den_q != '0);
			div_start_q <= (state_q == ST_GCD) && gcd_done;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= ratalu_pkg::op_t'(req_type);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (t1_done) begin
						num_q   <= num_comb;
						den_q   <= den_prod;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					// zero numerator or denominator: pass through unreduced
					if (num_q == '0 || den_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (divn_done) begin
						num_q   <= num_q[ratalu_pkg::NUM_W-1] ? (~{1'b0, quo_n} + 1'b1)
							: {1'b0, quo_n};
						den_q   <= den_q[ratalu_pkg::DEN_W-1] ? (~quo_d + 1'b1) : quo_d;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_num_q <= num_q;
						out_den_q <= den_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = $signed(out_num_q);
	assign res_den   = $signed(out_den_q);

	// the three multipliers run in lockstep
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(t1_done == t2_done) && (t1_done == den_done))
		else $error("multiplier done pulses out of step");

	// gcd only reports while the sequencer waits for it
	a_gcd_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_done |-> (state_q == ST_GCD))
		else $error("gcd done outside gcd state");

	// reduction by the gcd is exact on both parts
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		divn_done |-> (divd_done && rem_n == '0 && rem_d == '0))
		else $error("reduction left a remainder");

	// a result only enters the output register from the final state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output loaded outside final state");

endmodule

[hw/rtl/ratalu_mul.sv]
// ----------------------------------------------------------------------------
// ratalu_mul
// Serial signed multiplier: shift-add on magnitudes, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ratalu_mul (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] a,
	input  logic signed [ratalu_pkg::OPERAND_WIDTH-1:0] b,
	output logic                                        done,
	output logic signed [ratalu_pkg::PROD_W-1:0]        prod
);

	logic [ratalu_pkg::OPERAND_WIDTH-1:0] a_mag;
	logic [ratalu_pkg::OPERAND_WIDTH-1:0] b_mag;
	logic [ratalu_pkg::OPERAND_WIDTH-1:0] mcand_q;
	logic [ratalu_pkg::PROD_W-1:0]        acc_q;
	logic                                 neg_q;
	logic [ratalu_pkg::OP_CNT_W-1:0]      cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic [ratalu_pkg::OPERAND_WIDTH:0]   add_sum;

	assign a_mag = a[ratalu_pkg::OPERAND_WIDTH-1] ? (~a + 1'b1) : a;
	assign b_mag = b[ratalu_pkg::OPERAND_WIDTH-1] ? (~b + 1'b1) : b;

	// upper half plus multiplicand when the current multiplier bit is set
	assign add_sum = {1'b0, acc_q[ratalu_pkg::PROD_W-1:ratalu_pkg::OPERAND_WIDTH]}
		+ (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ratalu_pkg::OP_CNT_W'(ratalu_pkg::OPERAND_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= a_mag;
			acc_q   <= {{ratalu_pkg::OPERAND_WIDTH{1'b0}}, b_mag};
			neg_q   <= a[ratalu_pkg::OPERAND_WIDTH-1] ^ b[ratalu_pkg::OPERAND_WIDTH-1];
		end else if (busy_q) begin
			acc_q <= {add_sum, acc_q[ratalu_pkg::OPERAND_WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign prod = neg_q ? $signed(~acc_q + 1'b1) : $signed(acc_q);

endmodule

[hw/rtl/ratalu_gcd.sv]
// ----------------------------------------------------------------------------
// ratalu_gcd
// Binary gcd of two nonzero magnitudes: one shift or subtract-shift a cycle,
// then the common power of two is shifted back in one bit a cycle.
// ----------------------------------------------------------------------------
module ratalu_gcd (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ratalu_pkg::MAG_W-1:0] x,
	input  logic [ratalu_pkg::MAG_W-1:0] y,
	output logic                         done,
	output logic [ratalu_pkg::MAG_W-1:0] g
);

	typedef enum logic [1:0] {
		G_IDLE,
		G_RUN,
		G_SHL
	} gcd_state_t;

	gcd_state_t                        state_q;
	logic [ratalu_pkg::MAG_W-1:0]      x_q;
	logic [ratalu_pkg::MAG_W-1:0]      y_q;
	logic [ratalu_pkg::MAG_W-1:0]      g_q;
	logic [ratalu_pkg::MAG_CNT_W-1:0]  k_q;
	logic                              done_q;
	logic [ratalu_pkg::MAG_W:0]        diff_xy;
	logic [ratalu_pkg::MAG_W:0]        diff_yx;

	assign diff_xy = {1'b0, x_q} - {1'b0, y_q};
	assign diff_yx = {1'b0, y_q} - {1'b0, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			g_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == G_SHL) && (k_q == '0);
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						x_q     <= x;
						y_q     <= y;
						k_q     <= '0;
						state_q <= G_RUN;
					end
				end
				G_RUN: begin
					priority if (x_q == '0) begin
						g_q     <= y_q;
						state_q <= G_SHL;
					end else if (y_q == '0) begin
						g_q     <= x_q;
						state_q <= G_SHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (!diff_xy[ratalu_pkg::MAG_W]) begin
						// both odd: difference is even, halve it at once
						x_q <= diff_xy[ratalu_pkg::MAG_W:1];
					end else begin
						y_q <= diff_yx[ratalu_pkg::MAG_W:1];
					end
				end
				G_SHL: begin
					if (k_q == '0) begin
						state_q <= G_IDLE;
					end else begin
						g_q <= g_q << 1;
						k_q <= k_q - 1'b1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

[hw/rtl/ratalu_div.sv]
// ----------------------------------------------------------------------------
// ratalu_div
// Restoring unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ratalu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ratalu_pkg::MAG_W-1:0] dvd,
	input  logic [ratalu_pkg::MAG_W-1:0] dvs,
	output logic                         done,
	output logic [ratalu_pkg::MAG_W-1:0] quo,
	output logic [ratalu_pkg::MAG_W-1:0] rem
);

	logic [ratalu_pkg::MAG_W-1:0]     dvs_q;
	logic [ratalu_pkg::MAG_W-1:0]     rem_q;
	logic [ratalu_pkg::MAG_W-1:0]     quo_q;
	logic [ratalu_pkg::MAG_CNT_W-1:0] cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [ratalu_pkg::MAG_W:0]       trial;
	logic [ratalu_pkg::MAG_W:0]       diff;

	assign trial = {rem_q, quo_q[ratalu_pkg::MAG_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ratalu_pkg::MAG_CNT_W'(ratalu_pkg::MAG_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= dvs;
			rem_q <= '0;
			quo_q <= dvd;
		end else if (busy_q) begin
			if (!diff[ratalu_pkg::MAG_W]) begin
				rem_q <= diff[ratalu_pkg::MAG_W-1:0];
			end else begin
				rem_q <= trial[ratalu_pkg::MAG_W-1:0];
			end
			quo_q <= {quo_q[ratalu_pkg::MAG_W-2:0], ~diff[ratalu_pkg::MAG_W]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
